// ===== hdl/kbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed block transposition package
// Shared widths, register indexes, character constants and the command and
// status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kbt_pkg;

  localparam int unsigned CHAR_W            = 8;
  localparam int unsigned LEN_W             = 4;
  localparam int unsigned PERM_ENTRIES      = 8;
  localparam int unsigned PERM_ENTRY_W      = 3;
  localparam int unsigned PERM_W            = PERM_ENTRIES * PERM_ENTRY_W;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 24;
  localparam int unsigned MAX_BLOCK_DEFAULT = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_TABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

  // Register values after reset.
  localparam int unsigned           BLOCK_LEN_RESET  = 8;
  localparam logic [PERM_W-1:0]     PERM_TABLE_RESET = 24'd16434824;
  localparam logic                  DECRYPT_RESET    = 1'b0;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h58;
  localparam logic [CHAR_W-1:0] SEP_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] TAB_CHAR = 8'h09;
  localparam logic [CHAR_W-1:0] CR_CHAR  = 8'h0D;
  localparam logic [CHAR_W-1:0] LC_A     = 8'h61;
  localparam logic [CHAR_W-1:0] LC_Z     = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  // Source of the character loaded into the output register.
  typedef enum logic [1:0] {
    SRC_WS,
    SRC_SEP,
    SRC_PERM,
    SRC_NONE
  } src_e;

  typedef struct packed {
    logic                    accept;
    logic                    emit;
    src_e                    src;
    logic [PERM_ENTRY_W-1:0] pos;
    logic                    last;
    logic                    done;
    logic                    flush_end;
    logic                    msg_end;
  } cmd_t;

  typedef struct packed {
    logic             emit_ws;
    logic             will_flush;
    logic             need_sep;
    logic             eot;
    logic             out_free;
    logic [LEN_W-1:0] len;
  } status_t;

endpackage

// ===== hdl/kbt_if.sv =====
// ----------------------------------------------------------------------------
// Keyed block transposition channel interfaces
// Text input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface kbt_in_if import kbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              end_of_text;

  modport source (output valid, char_in, end_of_text, input ready);
  modport sink   (input valid, char_in, end_of_text, output ready);
endinterface

interface kbt_out_if import kbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last_of_run;
  logic              message_done;
  logic              no_char;

  modport source (output valid, char_out, last_of_run, message_done, no_char, input ready);
  modport sink   (input valid, char_out, last_of_run, message_done, no_char, output ready);
endinterface

interface kbt_cfg_if import kbt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/kbt_datapath.sv =====
// ----------------------------------------------------------------------------
// Keyed block transposition datapath
// Configuration registers, block buffer, fill state, permutation lookup and
// the output register.
// ----------------------------------------------------------------------------
module kbt_datapath import kbt_pkg::*; #(
  parameter int unsigned MaxBlock = MAX_BLOCK_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kbt_in_if.sink       in_i,
  kbt_out_if.source    out_o,
  kbt_cfg_if.sink      cfg_i,
  input  cmd_t         cmd_i,
  output status_t      status_o
);

  localparam int unsigned CapLen   = (MaxBlock < PERM_ENTRIES) ? MaxBlock : PERM_ENTRIES;
  localparam int unsigned IdxW     = $clog2(CapLen);
  localparam int unsigned LenReset = (BLOCK_LEN_RESET > CapLen) ? CapLen : BLOCK_LEN_RESET;

  logic [LEN_W-1:0]  len_q;
  logic [PERM_W-1:0] perm_q;
  logic              decrypt_q;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic              first_sent_q;
  logic [CHAR_W-1:0] buf_q [CapLen];
  logic [CHAR_W-1:0] ws_char_q;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q, out_done_q, out_none_q;

  logic              in_ws;
  logic [CHAR_W-1:0] norm_char;
  logic [LEN_W-1:0]  wr_idx;
  logic [LEN_W-1:0]  cfg_len;
  logic [CHAR_W-1:0] perm_char;

  assign cfg_i.ready = 1'b1;

  // Whitespace test and upper-casing of the incoming byte.
  assign in_ws = (in_i.char_in == SEP_CHAR) ||
                 ((in_i.char_in >= TAB_CHAR) && (in_i.char_in <= CR_CHAR));

  always_comb begin
    norm_char = in_i.char_in;
    if (!decrypt_q && (in_i.char_in >= LC_A) && (in_i.char_in <= LC_Z)) begin
      norm_char = in_i.char_in - CASE_OFS;
    end
  end

  // A shrunk block length makes the new character overwrite the last slot.
  assign wr_idx = (fill_q >= len_q) ? (len_q - LEN_W'(1)) : fill_q;
  assign fill_d = wr_idx + LEN_W'(1);

  always_comb begin
    cfg_len = cfg_i.data[LEN_W-1:0];
    if (cfg_len == '0) begin
      cfg_len = LEN_W'(1);
    end else if (cfg_len > LEN_W'(CapLen)) begin
      cfg_len = LEN_W'(CapLen);
    end
  end

  // Character for output position pos of the current block. Slots at or
  // above the fill count are pad characters of a message's final block.
  always_comb begin
    logic [PERM_ENTRY_W-1:0] p;
    logic                    hit;
    logic [IdxW-1:0]         hit_idx;
    p         = perm_q[cmd_i.pos*PERM_ENTRY_W +: PERM_ENTRY_W];
    hit       = 1'b0;
    hit_idx   = '0;
    perm_char = PAD_CHAR;
    if (decrypt_q) begin
      // The highest-numbered entry naming this position wins.
      for (int i = 0; i < CapLen; i++) begin
        if ((LEN_W'(i) < len_q) &&
            (perm_q[i*PERM_ENTRY_W +: PERM_ENTRY_W] == cmd_i.pos)) begin
          hit     = 1'b1;
          hit_idx = IdxW'(i);
        end
      end
      if (hit && (LEN_W'(hit_idx) < fill_q)) begin
        perm_char = buf_q[hit_idx];
      end
    end else begin
      if ((LEN_W'(p) < len_q) && (LEN_W'(p) < fill_q)) begin
        perm_char = buf_q[p[IdxW-1:0]];
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= LEN_W'(LenReset);
      perm_q       <= PERM_TABLE_RESET;
      decrypt_q    <= DECRYPT_RESET;
      fill_q       <= '0;
      first_sent_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_BLOCK_LEN:    len_q     <= cfg_len;
          CFG_PERM_TABLE:   perm_q    <= cfg_i.data[PERM_W-1:0];
          CFG_DECRYPT_MODE: decrypt_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      if (cmd_i.accept && !in_ws) begin
        fill_q <= fill_d;
      end else if (cmd_i.emit && (cmd_i.flush_end || cmd_i.msg_end)) begin
        fill_q <= '0;
      end
      // The end of a message clears the separator flag even when its last
      // block has just been sent.
      if (cmd_i.emit && cmd_i.msg_end) begin
        first_sent_q <= 1'b0;
      end else if (cmd_i.emit && cmd_i.flush_end && !decrypt_q) begin
        first_sent_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ws_char_q <= in_i.char_in;
      if (!in_ws) begin
        buf_q[wr_idx[IdxW-1:0]] <= norm_char;
      end
    end
    if (cmd_i.emit) begin
      out_last_q <= cmd_i.last;
      out_done_q <= cmd_i.done;
      out_none_q <= (cmd_i.src == SRC_NONE);
      unique case (cmd_i.src)
        SRC_WS:   out_char_q <= ws_char_q;
        SRC_SEP:  out_char_q <= SEP_CHAR;
        SRC_PERM: out_char_q <= perm_char;
        SRC_NONE: out_char_q <= '0;
        default:  out_char_q <= '0;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.char_out     = out_char_q;
  assign out_o.last_of_run  = out_last_q;
  assign out_o.message_done = out_done_q;
  assign out_o.no_char      = out_none_q;

  assign status_o.emit_ws    = in_ws && decrypt_q;
  assign status_o.will_flush = in_ws ? (in_i.end_of_text && (fill_q != '0))
                                     : ((fill_d >= len_q) || in_i.end_of_text);
  assign status_o.need_sep   = !decrypt_q && first_sent_q;
  assign status_o.eot        = in_i.end_of_text;
  assign status_o.out_free   = !out_valid_q || out_o.ready;
  assign status_o.len        = len_q;

endmodule

// ===== hdl/kbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyed block transposition controller
// Sequences the results of one accepted byte: a passed-through whitespace
// byte, a block separator, the permuted block and the end marker.
// ----------------------------------------------------------------------------
module kbt_ctrl import kbt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WS     = 3'd1;
  localparam logic [2:0] ST_SEP    = 3'd2;
  localparam logic [2:0] ST_PERM   = 3'd3;
  localparam logic [2:0] ST_NOCHAR = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [PERM_ENTRY_W-1:0] pos_q, pos_d;
  logic                    flush_q, flush_d;
  logic                    sep_q, sep_d;
  logic                    eot_q, eot_d;
  logic                    pos_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign pos_last   = ((LEN_W'(pos_q) + LEN_W'(1)) == status_i.len);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    flush_d = flush_q;
    sep_d   = sep_q;
    eot_d   = eot_q;
    cmd_o   = '{accept: 1'b0, emit: 1'b0, src: SRC_NONE, pos: pos_q, last: 1'b0,
                done: 1'b0, flush_end: 1'b0, msg_end: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          flush_d      = status_i.will_flush;
          sep_d        = status_i.need_sep;
          eot_d        = status_i.eot;
          pos_d        = '0;
          if (status_i.emit_ws) begin
            state_d = ST_WS;
          end else if (status_i.will_flush) begin
            state_d = status_i.need_sep ? ST_SEP : ST_PERM;
          end else if (status_i.eot) begin
            state_d = ST_NOCHAR;
          end
        end
      end
      ST_WS: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.src     = SRC_WS;
          cmd_o.last    = !flush_q;
          cmd_o.done    = eot_q && !flush_q;
          cmd_o.msg_end = eot_q && !flush_q;
          if (flush_q) begin
            state_d = sep_q ? ST_SEP : ST_PERM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEP: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_SEP;
          state_d    = ST_PERM;
        end
      end
      ST_PERM: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.src       = SRC_PERM;
          cmd_o.last      = pos_last;
          cmd_o.done      = pos_last && eot_q;
          cmd_o.flush_end = pos_last;
          cmd_o.msg_end   = pos_last && eot_q;
          pos_d           = pos_q + PERM_ENTRY_W'(1);
          if (pos_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_NOCHAR: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.src     = SRC_NONE;
          cmd_o.last    = 1'b1;
          cmd_o.done    = 1'b1;
          cmd_o.msg_end = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      flush_q <= 1'b0;
      sep_q   <= 1'b0;
      eot_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      flush_q <= flush_d;
      sep_q   <= sep_d;
      eot_q   <= eot_d;
    end
  end

endmodule

// ===== hdl/keyed_block_transposition_top.sv =====
// ----------------------------------------------------------------------------
// Keyed block transposition top level
// Byte-serial keyed columnar transposition with encrypt grouping and decrypt
// inverse permutation.
// ----------------------------------------------------------------------------
// The block takes one text byte per request on in_i and returns result
// requests on out_o. In encrypt mode whitespace is dropped, lower-case
// letters are made upper case and characters gather into a block of
// block_len; a full block leaves permuted, output position j carrying block
// entry perm[j], and every block after the first of a message is preceded by
// a space. In decrypt mode whitespace is passed straight through and output
// position perm[j] takes block entry j, a position that no entry names giving
// 'X'. On end of text a partial block is padded with 'X' and sent, and if
// nothing at all is sent for that byte a single result with no_char set marks
// the end of the message. A byte is taken only while the block is idle, and
// no new byte is taken until every result of the last one has been loaded
// into the output register, one result per cycle while out_o is ready: the
// controller walks the block one output position per cycle through a single
// output register. A finished result waits in the output register until the
// consumer takes it and the controller stalls meanwhile; while out_o is ready
// a new result is loaded in the same cycle that the previous one leaves.
// Configuration writes on cfg_i are always accepted and must only be made
// while no message byte is being processed.
module keyed_block_transposition_top import kbt_pkg::*; #(
  parameter int unsigned MaxBlock = MAX_BLOCK_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kbt_in_if.sink    in_i,
  kbt_out_if.source out_o,
  kbt_cfg_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // The controller owns the input handshake; the datapath sees only the
  // payload and the commands derived from it.
  assign in_i.ready = in_ready;

  kbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kbt_datapath #(
    .MaxBlock (MaxBlock)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Keyed block transposition testbench
// Sends text requests and register writes into the block and predicts every
// result request with a behavioural model kept inside the bench. Results are
// checked in order, field by field. Both sides idle at random, and the
// receiver once holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import kbt_pkg::*;

  // Cycles the receiver refuses results during the pressure phase.
  localparam int unsigned HOLD_CYCLES   = 200;
  // Quiet cycles allowed after the last expected result before a register
  // write, covering a dropped byte still moving through the controller.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Cycles without any accepted request before the run is declared hung.
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RAND_PHASES   = 10;
  localparam int unsigned PHASE_BYTES   = 30;
  localparam int unsigned BLK_CAP       =
    (MAX_BLOCK_DEFAULT < PERM_ENTRIES) ? MAX_BLOCK_DEFAULT : PERM_ENTRIES;
  localparam int unsigned DIR_ROWS      = 31;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              done;
    logic              no_ch;
  } text_res_t;

  typedef enum logic {ROW_TEXT, ROW_REG} row_kind_e;

  // One directed step. On text rows the low byte of value is the character
  // and idx is unused; where typed is set, want holds the expected characters
  // (want_n of them, first character leftmost) in place of the prediction.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  eot;
    logic                  typed;
    logic [3:0]            want_n;
    logic [63:0]           want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  kbt_in_if  in_if ();
  kbt_out_if out_if ();
  kbt_cfg_if cfg_if ();

  keyed_block_transposition_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Bench copy of the cipher state and its registers.
  logic [CHAR_W-1:0] blk_buf [BLK_CAP];
  int unsigned       blk_fill;
  bit                sep_due;
  logic [LEN_W-1:0]  key_len;
  logic [PERM_W-1:0] key_perm;
  logic              key_dec;

  // Results caused by the request in hand, and all results still awaited.
  text_res_t burst_q [$];
  text_res_t pending_q [$];

  bit          calm;
  bit          hold_req;
  int unsigned err_count;
  int unsigned text_sent;
  int unsigned directed_sent;
  int unsigned results_seen;
  int unsigned regs_written;
  int unsigned quiet_cycles;

  // The directed part starts from the reset registers (block of eight,
  // identity key, encrypt) and walks through the corner cases: an end of
  // text with nothing buffered, the byte extremes, a block length of zero
  // and one above the limit, a key of all sevens and all zeros, whitespace
  // passing through in decrypt, repeated key entries, key entries beyond the
  // block, and a block length shrunk while a block is half full.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_TEXT, CFG_BLOCK_LEN,    " ",          1'b1, 1'b1, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "a",          1'b0, 1'b1, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    24'h00,       1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    24'hFF,       1'b1, 1'b0, 4'd0, 64'h0},
    '{ROW_REG,  CFG_BLOCK_LEN,    24'd0,        1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "z",          1'b0, 1'b1, 4'd1, "Z"},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "a",          1'b1, 1'b1, 4'd2, " A"},
    '{ROW_REG,  CFG_BLOCK_LEN,    24'd15,       1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_REG,  CFG_PERM_TABLE,   24'hFFFFFF,   1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "q",          1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    24'h0D,       1'b0, 1'b1, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "r",          1'b1, 1'b0, 4'd0, 64'h0},
    '{ROW_REG,  CFG_PERM_TABLE,   24'h000000,   1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_REG,  CFG_BLOCK_LEN,    24'd3,        1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_REG,  CFG_DECRYPT_MODE, 24'd1,        1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    24'h09,       1'b0, 1'b1, 4'd1, "\t"},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "a",          1'b0, 1'b1, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "b",          1'b0, 1'b1, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "c",          1'b0, 1'b1, 4'd3, "cXX"},
    '{ROW_TEXT, CFG_BLOCK_LEN,    " ",          1'b1, 1'b1, 4'd1, " "},
    '{ROW_REG,  CFG_PERM_TABLE,   24'h00000A,   1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "x",          1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "~",          1'b1, 1'b0, 4'd0, 64'h0},
    '{ROW_REG,  CFG_DECRYPT_MODE, 24'd0,        1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_REG,  CFG_BLOCK_LEN,    24'd8,        1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "k",          1'b0, 1'b1, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "l",          1'b0, 1'b1, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "m",          1'b0, 1'b1, 4'd0, 64'h0},
    '{ROW_REG,  CFG_BLOCK_LEN,    24'd2,        1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    "n",          1'b0, 1'b0, 4'd0, 64'h0},
    '{ROW_TEXT, CFG_BLOCK_LEN,    24'h0B,       1'b1, 1'b1, 4'd0, 64'h0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Cipher prediction
  // ------------------------------------------------------------------------

  // A block length of zero behaves as one, and anything above the buffer
  // size behaves as the buffer size.
  function automatic int unsigned active_len();
    int unsigned n;
    n = key_len;
    if (n == 0) n = 1;
    if (n > BLK_CAP) n = BLK_CAP;
    return n;
  endfunction

  function automatic int unsigned key_entry(int unsigned j);
    return key_perm[PERM_ENTRY_W*j +: PERM_ENTRY_W];
  endfunction

  function automatic bit is_blank(logic [CHAR_W-1:0] c);
    return (c == SEP_CHAR) || (c >= TAB_CHAR && c <= CR_CHAR);
  endfunction

  function automatic void push_char(logic [CHAR_W-1:0] c);
    burst_q.insert(burst_q.size(), '{c, 1'b0, 1'b0, 1'b0});
  endfunction

  // Marks the final result of the request, and of the message on its end.
  function automatic void close_burst(logic eot);
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size()-1].last = 1'b1;
      if (eot) burst_q[burst_q.size()-1].done = 1'b1;
    end
  endfunction

  // Sends the first len buffer entries through the key. Encrypt gathers
  // output j from entry key[j]; decrypt scatters entry j to output key[j],
  // the later entry winning a collision. Anything out of reach reads as pad.
  function automatic void emit_block(int unsigned len);
    logic [CHAR_W-1:0] slot [BLK_CAP];
    int unsigned       j;
    int unsigned       p;
    if (key_dec) begin
      for (j = 0; j < len; j++) slot[j] = PAD_CHAR;
      for (j = 0; j < len; j++) begin
        p = key_entry(j);
        if (p < len) slot[p] = blk_buf[j];
      end
      for (j = 0; j < len; j++) push_char(slot[j]);
    end else begin
      if (sep_due) push_char(SEP_CHAR);
      for (j = 0; j < len; j++) begin
        p = key_entry(j);
        push_char((p < len) ? blk_buf[p] : PAD_CHAR);
      end
      sep_due = 1'b1;
    end
    blk_fill = 0;
  endfunction

  function automatic void predict_text(logic [CHAR_W-1:0] c, logic eot);
    logic [CHAR_W-1:0] ch;
    int unsigned       len;
    int unsigned       slot_idx;
    int unsigned       k;
    burst_q.delete();
    ch  = c;
    len = active_len();
    if (is_blank(ch)) begin
      if (key_dec) push_char(ch);
    end else begin
      if (!key_dec && ch >= LC_A && ch <= LC_Z) ch = ch - CASE_OFS;
      // A block length shrunk under a fuller buffer overwrites the last slot.
      slot_idx = (blk_fill >= len) ? len - 1 : blk_fill;
      blk_buf[slot_idx] = ch;
      blk_fill = slot_idx + 1;
      if (blk_fill >= len) emit_block(len);
    end
    if (eot) begin
      if (blk_fill > 0) begin
        for (k = blk_fill; k < len; k++) blk_buf[k] = PAD_CHAR;
        emit_block(len);
      end
      blk_fill = 0;
      sep_due  = 1'b0;
      // With nothing else to send, a bare end marker closes the message.
      if (burst_q.size() == 0) burst_q.insert(0, '{'0, 1'b0, 1'b0, 1'b1});
    end
    close_burst(eot);
  endfunction

  // ------------------------------------------------------------------------
  // Random choices
  // ------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    unique case (r)
      0:       return '0;
      1:       return '1;
      2:       return LEN_W'(1);
      3:       return LEN_W'(BLK_CAP);
      4:       return LEN_W'($urandom_range(BLK_CAP + 1, 14));
      default: return LEN_W'($urandom_range(1, BLK_CAP));
    endcase
  endfunction

  // Most keys are true permutations of the block positions; the rest are
  // raw bits, all zeros, all ones or the identity.
  function automatic logic [PERM_W-1:0] pick_perm(int unsigned len);
    int unsigned                r;
    int unsigned                j;
    int unsigned                k;
    logic [PERM_ENTRY_W-1:0]    ent [PERM_ENTRIES];
    logic [PERM_ENTRY_W-1:0]    t;
    logic [PERM_W-1:0]          v;
    r = $urandom_range(0, 99);
    if (r < 15) return PERM_W'($urandom());
    if (r < 20) return '0;
    if (r < 25) return '1;
    if (r < 30) return PERM_TABLE_RESET;
    for (j = 0; j < PERM_ENTRIES; j++) ent[j] = PERM_ENTRY_W'(j);
    for (j = len - 1; j > 0; j--) begin
      k      = $urandom_range(0, j);
      t      = ent[j];
      ent[j] = ent[k];
      ent[k] = t;
    end
    for (j = len; j < PERM_ENTRIES; j++) ent[j] = PERM_ENTRY_W'($urandom_range(0, 7));
    for (j = 0; j < PERM_ENTRIES; j++) v[PERM_ENTRY_W*j +: PERM_ENTRY_W] = ent[j];
    return v;
  endfunction

  // Plain text for the most part, with whitespace and arbitrary bytes mixed in.
  function automatic logic [CHAR_W-1:0] pick_byte();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 45) return CHAR_W'($urandom_range(LC_A, LC_Z));
    if (r < 65) return CHAR_W'($urandom_range(LC_A - CASE_OFS, LC_Z - CASE_OFS));
    if (r < 80) begin
      k = $urandom_range(0, 5);
      return (k == 5) ? SEP_CHAR : TAB_CHAR + CHAR_W'(k);
    end
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // ------------------------------------------------------------------------
  // Request driving
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    if (err_count < 40) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
               want_v, got_v);
    end
    err_count++;
  endtask

  // Waits until every awaited result has arrived and the block has had time
  // to finish any byte that produces nothing.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_text(input logic [CHAR_W-1:0] c, input logic eot, input logic typed,
                           input logic [3:0] want_n, input logic [63:0] want);
    int unsigned gap;
    int          k;
    in_if.valid       <= 1'b1;
    in_if.char_in     <= c;
    in_if.end_of_text <= eot;
    do @(posedge clk); while (!in_if.ready);
    text_sent++;
    // The prediction always runs so that the bench state follows the block,
    // but a typed row replaces what it produced.
    predict_text(c, eot);
    if (typed) begin
      burst_q.delete();
      for (k = 0; k < int'(want_n); k++) push_char(want[8*(int'(want_n)-1-k) +: 8]);
      if (want_n == 0 && eot) burst_q.insert(0, '{'0, 1'b0, 1'b0, 1'b1});
      close_burst(eot);
    end
    foreach (burst_q[i]) pending_q.insert(pending_q.size(), burst_q[i]);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    regs_written++;
    unique case (idx)
      CFG_BLOCK_LEN:    key_len  = val[LEN_W-1:0];
      CFG_PERM_TABLE:   key_perm = val[PERM_W-1:0];
      CFG_DECRYPT_MODE: key_dec  = val[0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Receiver: random ready with occasional long refusals, and the single
  // long hold-off that fills the block up.
  // ------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  end

  // ------------------------------------------------------------------------
  // Result checking: each accepted result against the oldest expectation.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    text_res_t got;
    text_res_t want_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.char_out, out_if.last_of_run, out_if.message_done, out_if.no_char};
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("result with none awaited, char_out", 0, got.ch);
      end else begin
        want_r = pending_q.pop_front();
        if (got.ch !== want_r.ch) report_mismatch("char_out", want_r.ch, got.ch);
        if (got.last !== want_r.last)
          report_mismatch("last_of_run", want_r.last, got.last);
        if (got.done !== want_r.done)
          report_mismatch("message_done", want_r.done, got.done);
        if (got.no_ch !== want_r.no_ch) report_mismatch("no_char", want_r.no_ch, got.no_ch);
      end
    end
  end

  // Watchdog: a long stretch with no request accepted on any channel means
  // the block has hung or lost a result.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a request, %0d results still awaited",
               quiet_cycles, pending_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  initial begin
    int unsigned       i;
    int unsigned       phase;
    int unsigned       counted;
    int unsigned       msg_left;
    int unsigned       eff;
    logic [LEN_W-1:0]  len_v;
    logic [CHAR_W-1:0] c;
    logic              eot;
    dir_row_t          row;

    clk               = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.char_in     = '0;
    in_if.end_of_text = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_BLOCK_LEN;
    cfg_if.data       = '0;
    calm              = 1'b0;
    hold_req          = 1'b0;
    err_count         = 0;
    text_sent         = 0;
    results_seen      = 0;
    regs_written      = 0;
    quiet_cycles      = 0;
    blk_fill          = 0;
    sep_due           = 1'b0;
    key_len           = LEN_W'(BLOCK_LEN_RESET);
    key_perm          = PERM_TABLE_RESET;
    key_dec           = DECRYPT_RESET;
    foreach (blk_buf[j]) blk_buf[j] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.idx, row.value);
      end else begin
        send_text(row.value[CHAR_W-1:0], row.eot, row.typed, row.want_n, row.want);
      end
    end
    directed_sent = text_sent;

    // Random phases: each sets all three registers, then sends messages of
    // random length, mostly closed by an end of text, some cut short by a
    // stray end of text or by the end of the phase. A phase may stop in the
    // middle of a block, so the next settings apply to a half-filled buffer.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      len_v = pick_len();
      eff   = (len_v == 0) ? 1 : ((len_v > BLK_CAP) ? BLK_CAP : len_v);
      write_reg(CFG_BLOCK_LEN, CFG_DATA_W'(len_v));
      write_reg(CFG_PERM_TABLE, CFG_DATA_W'(pick_perm(eff)));
      write_reg(CFG_DECRYPT_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      // The fourth phase runs the long hold-off with the sender offering
      // back to back; two later phases run with no idling at all.
      calm = (phase == 3) || (phase == 5) || (phase == 6);
      if (phase == 3) hold_req = 1'b1;
      counted  = 0;
      msg_left = $urandom_range(0, 3 * eff + 2);
      while (counted < PHASE_BYTES) begin
        c = pick_byte();
        if (msg_left == 0) begin
          eot      = 1'b1;
          msg_left = $urandom_range(0, 3 * eff + 2);
        end else begin
          eot      = ($urandom_range(0, 19) == 0);
          msg_left = msg_left - 1;
        end
        // Whitespace dropped in encrypt is not counted towards the phase.
        if (!(is_blank(c) && !key_dec && !eot)) counted++;
        send_text(c, eot, 1'b0, 4'd0, 64'h0);
      end
    end
    calm = 1'b0;

    drain_results();
    $display("Covered %0d text requests (%0d directed) over %0d register writes,",
             text_sent, directed_sent, regs_written);
    $display("with %0d results checked and one %0d-cycle receiver hold-off; %0d mismatches.",
             results_seen, HOLD_CYCLES, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
